// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
// Define ASSERT_OFF to drop every assertion from the build.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every rising edge outside reset.
`define ASSERT_HOLD(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// When cond holds, expr must hold in the cycle after.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
        else $error("assertion failed");

`else

`define ASSERT_HOLD(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, cond, expr)

`endif

`endif

// File: hw/rtl/pss_pkg.sv
package pss_pkg;

    localparam int KEY_W       = 16;
    localparam int TIME_W      = 32;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = 5;

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_ADD    = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_START  = 3'd3,
        CMD_STOP   = 3'd4,
        CMD_QUERY  = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_SEND  = 2'd0,
        KIND_IDLE  = 2'd1,
        KIND_ACK   = 2'd2,
        KIND_QUERY = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] interval;
        logic [TIME_W-1:0] stamp;
        logic              enabled;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;  // capture the input beat, restart the scan
        logic rd;    // read the slot at the scan index
        logic ev;    // evaluate the slot just read
        logic fin;   // apply the command and issue the final result
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_slot;  // scan index is on the final slot
        logic ev_ok;      // evaluation step can complete this cycle
        logic fin_ok;     // result register can take the final result
    } sts_t;

endpackage

// File: hw/rtl/pss_ctrl.sv
module pss_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  pss_pkg::sts_t sts,
    output pss_pkg::ctl_t ctl
);

    pss_pkg::state_t state_reg;
    pss_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pss_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            pss_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ctl.load   = 1'b1;
                    state_next = pss_pkg::ST_READ;
                end
            end
            pss_pkg::ST_READ: begin
                ctl.rd     = 1'b1;
                state_next = pss_pkg::ST_EVAL;
            end
            pss_pkg::ST_EVAL: begin
                ctl.ev = 1'b1;
                if (sts.ev_ok) begin
                    state_next = sts.last_slot ? pss_pkg::ST_FINISH : pss_pkg::ST_READ;
                end
            end
            pss_pkg::ST_FINISH: begin
                ctl.fin = 1'b1;
                if (sts.fin_ok) begin
                    state_next = pss_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pss_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/pss_dp.sv
module pss_dp #(
    parameter int SLOTS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  pss_pkg::ctl_t ctl,
    output pss_pkg::sts_t sts,
    input  logic [79:0]   s_tdata,
    input  logic [2:0]    s_tuser,
    input  logic          cfg_valid,
    input  logic          cfg_data,
    input  logic          m_tready,
    output logic          m_tvalid,
    output logic [87:0]   m_tdata,
    output logic [1:0]    m_tuser,
    output logic          m_tlast
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int KW    = pss_pkg::KEY_W;
    localparam int TW    = pss_pkg::TIME_W;

    // Slot store; the valid bits say which entries hold a key.
    pss_pkg::entry_t mem [SLOTS];
    logic [SLOTS-1:0] valid_reg;

    pss_pkg::cmd_t  cmd_reg;
    logic [KW-1:0]  key_reg;
    logic [TW-1:0]  ivl_reg;
    logic [TW-1:0]  now_reg;
    logic           master_enable_reg;

    logic [IDX_W-1:0]         idx_reg;
    pss_pkg::entry_t          rd_data_reg;
    logic [pss_pkg::CNT_W-1:0] cnt_reg;
    logic                     pend_valid_reg;
    logic [KW-1:0]            pend_key_reg;
    logic                     match_valid_reg;
    logic [IDX_W-1:0]         match_idx_reg;
    pss_pkg::entry_t          match_entry_reg;
    logic                     free_valid_reg;
    logic [IDX_W-1:0]         free_idx_reg;

    logic           m_valid_reg;
    pss_pkg::kind_t out_kind_reg;
    logic [KW-1:0]  out_key_reg;
    logic [TW-1:0]  out_elapsed_reg;
    logic [TW-1:0]  out_last_time_reg;
    logic           out_en_reg;
    logic           out_found_reg;
    logic           out_last_reg;

    logic            out_free;
    logic            slot_valid;
    logic            is_tick;
    logic [TW-1:0]   slot_elapsed;
    logic            due;
    logic            ev_go;
    logic            fin_go;
    logic            hit;
    logic            free_hit;

    logic            mem_we;
    logic [IDX_W-1:0] mem_waddr;
    pss_pkg::entry_t mem_wdata;
    logic            valid_set;
    logic            valid_clr;
    logic [IDX_W-1:0] valid_idx;

    logic            out_load;
    pss_pkg::kind_t  out_kind_next;
    logic [KW-1:0]   out_key_next;
    logic [TW-1:0]   out_elapsed_next;
    logic [TW-1:0]   out_last_time_next;
    logic            out_en_next;
    logic            out_found_next;
    logic            out_last_next;

    assign out_free     = !m_valid_reg || m_tready;
    assign slot_valid   = valid_reg[idx_reg];
    assign is_tick      = (cmd_reg == pss_pkg::CMD_TICK);
    assign slot_elapsed = now_reg - rd_data_reg.stamp;

    assign due = is_tick && master_enable_reg
                 && (cnt_reg < pss_pkg::CNT_W'(pss_pkg::MAX_RESULTS))
                 && slot_valid && rd_data_reg.enabled
                 && (slot_elapsed > rd_data_reg.interval);

    assign hit      = !is_tick && (key_reg != '0) && slot_valid
                      && (rd_data_reg.key == key_reg) && !match_valid_reg;
    assign free_hit = !slot_valid && !free_valid_reg;

    assign sts.ev_ok     = !(due && pend_valid_reg) || out_free;
    assign sts.fin_ok    = out_free;
    assign sts.last_slot = (idx_reg == IDX_W'(SLOTS - 1));

    assign ev_go  = ctl.ev && sts.ev_ok;
    assign fin_go = ctl.fin && out_free;

    // Store updates and result selection.
    always_comb begin
        mem_we             = 1'b0;
        mem_waddr          = idx_reg;
        mem_wdata          = rd_data_reg;
        valid_set          = 1'b0;
        valid_clr          = 1'b0;
        valid_idx          = match_idx_reg;
        out_load           = 1'b0;
        out_kind_next      = pss_pkg::KIND_ACK;
        out_key_next       = key_reg;
        out_elapsed_next   = '0;
        out_last_time_next = '0;
        out_en_next        = 1'b0;
        out_found_next     = 1'b0;
        out_last_next      = 1'b1;

        if (ev_go && due) begin
            // stamp the due slot; flush the earlier pending send
            mem_we          = 1'b1;
            mem_wdata.stamp = now_reg;
            if (pend_valid_reg) begin
                out_load      = 1'b1;
                out_kind_next = pss_pkg::KIND_SEND;
                out_key_next  = pend_key_reg;
                out_last_next = 1'b0;
            end
        end

        if (fin_go) begin
            out_load = 1'b1;
            case (cmd_reg) inside
                pss_pkg::CMD_TICK: begin
                    if (pend_valid_reg) begin
                        out_kind_next = pss_pkg::KIND_SEND;
                        out_key_next  = pend_key_reg;
                    end else begin
                        out_kind_next = pss_pkg::KIND_IDLE;
                        out_key_next  = '0;
                    end
                end
                pss_pkg::CMD_QUERY: begin
                    out_kind_next = pss_pkg::KIND_QUERY;
                    if (match_valid_reg) begin
                        out_elapsed_next   = now_reg - match_entry_reg.stamp;
                        out_last_time_next = match_entry_reg.stamp;
                        out_en_next        = match_entry_reg.enabled;
                        out_found_next     = 1'b1;
                    end
                end
                pss_pkg::CMD_ADD: begin
                    if (match_valid_reg) begin
                        out_found_next = 1'b1;
                        if (ivl_reg != '0) begin
                            mem_we             = 1'b1;
                            mem_waddr          = match_idx_reg;
                            mem_wdata          = match_entry_reg;
                            mem_wdata.interval = ivl_reg;
                        end else begin
                            valid_clr = 1'b1;
                        end
                    end else if ((key_reg != '0) && (ivl_reg != '0) && free_valid_reg) begin
                        out_found_next      = 1'b1;
                        mem_we              = 1'b1;
                        mem_waddr           = free_idx_reg;
                        mem_wdata.key       = key_reg;
                        mem_wdata.interval  = ivl_reg;
                        mem_wdata.stamp     = '0;
                        mem_wdata.enabled   = 1'b1;
                        valid_set           = 1'b1;
                        valid_idx           = free_idx_reg;
                    end
                end
                pss_pkg::CMD_REMOVE: begin
                    out_found_next = match_valid_reg;
                    valid_clr      = match_valid_reg;
                end
                pss_pkg::CMD_START, pss_pkg::CMD_STOP: begin
                    out_found_next    = match_valid_reg;
                    mem_we            = match_valid_reg;
                    mem_waddr         = match_idx_reg;
                    mem_wdata         = match_entry_reg;
                    mem_wdata.enabled = (cmd_reg == pss_pkg::CMD_START);
                end
                default: begin
                    out_found_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.rd) begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    // Input capture and search results (payload).
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            cmd_reg <= pss_pkg::cmd_t'(s_tuser);
            key_reg <= s_tdata[15:0];
            ivl_reg <= s_tdata[47:16];
            now_reg <= s_tdata[79:48];
        end
        if (ev_go && due) begin
            pend_key_reg <= rd_data_reg.key;
        end
        if (ctl.ev && hit) begin
            match_idx_reg   <= idx_reg;
            match_entry_reg <= rd_data_reg;
        end
        if (ctl.ev && free_hit) begin
            free_idx_reg <= idx_reg;
        end
        if (out_load) begin
            out_kind_reg      <= out_kind_next;
            out_key_reg       <= out_key_next;
            out_elapsed_reg   <= out_elapsed_next;
            out_last_time_reg <= out_last_time_next;
            out_en_reg        <= out_en_next;
            out_found_reg     <= out_found_next;
            out_last_reg      <= out_last_next;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg         <= '0;
            master_enable_reg <= 1'b1;
            idx_reg           <= '0;
            cnt_reg           <= '0;
            pend_valid_reg    <= 1'b0;
            match_valid_reg   <= 1'b0;
            free_valid_reg    <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_valid) begin
                master_enable_reg <= cfg_data;
            end
            if (valid_set) begin
                valid_reg[valid_idx] <= 1'b1;
            end
            if (valid_clr) begin
                valid_reg[valid_idx] <= 1'b0;
            end
            if (ctl.load) begin
                idx_reg         <= '0;
                cnt_reg         <= '0;
                pend_valid_reg  <= 1'b0;
                match_valid_reg <= 1'b0;
                free_valid_reg  <= 1'b0;
            end else begin
                if (ev_go) begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (ev_go && due) begin
                    cnt_reg        <= cnt_reg + 1'b1;
                    pend_valid_reg <= 1'b1;
                end
                if (ctl.ev && hit) begin
                    match_valid_reg <= 1'b1;
                end
                if (ctl.ev && free_hit) begin
                    free_valid_reg <= 1'b1;
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, out_found_reg, out_en_reg, out_last_time_reg,
                       out_elapsed_reg, out_key_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: hw/rtl/periodic_send_scheduler_top.sv
// Channel   Dir  Handshake            Payload
// s_        in   s_tvalid/s_tready    tuser: cmd; tdata: key, interval, now_ms
// m_        out  m_tvalid/m_tready    tuser: kind; tdata: send_key, elapsed, ...;
//                                     tlast: last result of the command
// cfg_      in   cfg_valid/cfg_ready  master_enable
//
// Each command scans every slot. The slot store has one registered read
// port, so the scan reads one slot and evaluates it in the next cycle. A
// stalled result side holds the scan on a due slot while an earlier send
// is pending, or holds the final step. The next beat is taken as soon as
// the final result sits in the output register. Reset is synchronous,
// active low; it empties every slot at once through per-slot valid bits
// and sets master_enable.

`include "assert_macros.svh"

module periodic_send_scheduler_top #(
    parameter int SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // [15:0] key, [47:16] interval, [79:48] now_ms
    input  logic [2:0]  s_tuser,   // [2:0] cmd

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // [15:0] send_key, [47:16] elapsed,
                                   // [79:48] last_time, [80] enabled_flag,
                                   // [81] found, [87:82] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data   // master_enable
);

    pss_pkg::ctl_t ctl;
    pss_pkg::sts_t sts;

    // The enable register can be written in any cycle.
    assign cfg_ready = 1'b1;

    // Sequencer: capture, per-slot read and evaluate, final step.
    pss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // Slot store, search, stamping and the output register.
    pss_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // A captured beat blocks the input until its command has finished.
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // The final step always leaves a last-marked result in the output register.
    `ASSERT_NEXT(a_final_result, aclk, aresetn, ctl.fin && sts.fin_ok, m_tvalid && m_tlast)
    // Scan steps and the final step never overlap with capture.
    `ASSERT_HOLD(a_one_step, aclk, aresetn, !(ctl.load && (ctl.rd || ctl.ev || ctl.fin)))

endmodule
